// ===== hw/rtl/smt_pkg.sv =====
// Shared types, codes and constants of the sorted address membership table.
package smt_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int ADDR_W           = 32;
   localparam int COUNT_FIELD_W    = 5;
   localparam int STATUS_W         = 2;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_POP    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Update applied to the slot row in the execute cycle
   typedef enum logic [1:0] {
      OP_HOLD      = 2'd0,
      OP_INSERT    = 2'd1,
      OP_SHIFT_GE  = 2'd2,
      OP_SHIFT_ALL = 2'd3
   } shift_op_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_COMPARE = 2'd1,
      ST_EXECUTE = 2'd2
   } state_type;

   typedef struct packed {
      logic         capture;
      logic         compare;
      shift_op_type op;
      logic         load_rsp;
      status_type   rsp_status;
      logic         rsp_present;
      logic         take_head;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     found;
      logic     full;
      logic     empty;
   } dp_status_type;

endpackage

// ===== hw/rtl/sorted_ip_membership_table.sv =====
// Top level of the sorted client address membership table.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  req_    | in        | client_address[31:0]                        | mode[1:0]
//  rsp_    | out       | status[1:0] present[2] popped_address[34:3] | -
//          |           | entry_count[39:35]                          |
//
// Each item passes through three steps: accept, compare the address against every slot in
// parallel, then shift the slot row and load the result register. The slot row
// update is the limiting step; req_tready stays low from the cycle after accept
// through execute, and the result is offered from the cycle after execute.
// Execute waits while a previous result is still unread, so a stalled rsp_ side
// holds the next item in flight. Reset empties the table at once; slots need none.
module sorted_ip_membership_table
   import smt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // client_address[31:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], present[2], popped_address[34:3],
                                    // entry_count[39:35]
);

   dp_cmd_type               dp_cmd;
   dp_status_type            dp_status;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_present;
   logic [ADDR_W-1:0]        rsp_popped_address;
   logic [COUNT_FIELD_W-1:0] rsp_entry_count;

   // Sequence each item and hold the result valid until taken
   smt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // Keep the slots sorted and form the result fields
   smt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_tuser),
      .req_address        (req_tdata),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .rsp_status         (rsp_status),
      .rsp_present        (rsp_present),
      .rsp_popped_address (rsp_popped_address),
      .rsp_entry_count    (rsp_entry_count)
   );

   assign rsp_tdata = {rsp_entry_count, rsp_popped_address, rsp_present, rsp_status};

endmodule

// ===== hw/rtl/smt_ctrl.sv =====
// Controller state machine: sequences capture, compare and execute, owns the result valid.
module smt_ctrl
   import smt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_EXECUTE;
         ST_EXECUTE: if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      dp_cmd             = '0;
      dp_cmd.op          = OP_HOLD;
      dp_cmd.rsp_status  = STATUS_OK;
      req_tready         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            dp_cmd.capture = req_tvalid;
         end
         ST_COMPARE: begin
            dp_cmd.compare = 1'b1;
         end
         ST_EXECUTE: begin
            if (out_free) begin
               dp_cmd.load_rsp = 1'b1;
               unique case (dp_status.mode)
                  MODE_ADD: begin
                     if (dp_status.full) begin
                        dp_cmd.rsp_status = STATUS_FULL;
                     end else begin
                        dp_cmd.op = OP_INSERT;
                     end
                  end
                  MODE_REMOVE: begin
                     if (dp_status.found) begin
                        dp_cmd.op = OP_SHIFT_GE;
                     end else begin
                        dp_cmd.rsp_status = STATUS_NONE;
                     end
                  end
                  MODE_SEARCH: begin
                     dp_cmd.rsp_present = dp_status.found;
                     if (!dp_status.found) dp_cmd.rsp_status = STATUS_NONE;
                  end
                  MODE_POP: begin
                     if (dp_status.empty) begin
                        dp_cmd.rsp_status = STATUS_NONE;
                     end else begin
                        dp_cmd.op        = OP_SHIFT_ALL;
                        dp_cmd.take_head = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = dp_cmd.load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/smt_datapath.sv =====
// Datapath: sorted slot row with per-slot comparators, entry count and result register.
module smt_datapath
   import smt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_mode,
   input  logic [ADDR_W-1:0]        req_address,
   input  dp_cmd_type               dp_cmd,
   output dp_status_type            dp_status,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_present,
   output logic [ADDR_W-1:0]        rsp_popped_address,
   output logic [COUNT_FIELD_W-1:0] rsp_entry_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [ADDR_W-1:0]        slots_ff [CAPACITY];
   logic [ADDR_W-1:0]        slots_in [CAPACITY];
   logic [CAPACITY-1:0]      gt_ff, gt_in, ge_ff, ge_in, eq_ff, eq_in;
   logic [CW-1:0]            count_ff, count_in;
   mode_type                 mode_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic                     rsp_present_ff;
   logic [ADDR_W-1:0]        rsp_popped_ff;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ADDR_W-1:0] prev_slot, next_slot;
      logic              prev_gt, valid, at_end;

      if (i == 0) begin : g_head
         assign prev_slot = addr_ff;
         assign prev_gt   = 1'b0;
      end else begin : g_body
         assign prev_slot = slots_ff[i-1];
         assign prev_gt   = gt_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_slot = slots_ff[i];
      end else begin : g_mid
         assign next_slot = slots_ff[i+1];
      end

      assign valid    = CW'(i) < count_ff;
      assign at_end   = count_ff == CW'(i);
      assign gt_in[i] = valid && (slots_ff[i] >  addr_ff);
      assign ge_in[i] = valid && (slots_ff[i] >= addr_ff);
      assign eq_in[i] = valid && (slots_ff[i] == addr_ff);

      // Insert: shift the greater entries up one place, drop the address in the gap; remove and pop shift down
      always_comb begin
         case (dp_cmd.op)
            OP_INSERT: begin
               if (prev_gt) slots_in[i] = prev_slot;
               else if (gt_ff[i] || at_end) slots_in[i] = addr_ff;
               else slots_in[i] = slots_ff[i];
            end
            OP_SHIFT_GE:  slots_in[i] = ge_ff[i] ? next_slot : slots_ff[i];
            OP_SHIFT_ALL: slots_in[i] = next_slot;
            default:      slots_in[i] = slots_ff[i];
         endcase
      end
   end

   always_comb begin
      case (dp_cmd.op) inside
         OP_INSERT:                 count_in = count_ff + CW'(1);
         OP_SHIFT_GE, OP_SHIFT_ALL: count_in = count_ff - CW'(1);
         default:                   count_in = count_ff;
      endcase
   end

   assign dp_status.mode  = mode_ff;
   assign dp_status.found = |eq_ff;
   assign dp_status.full  = count_ff == CW'(CAPACITY);
   assign dp_status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         addr_ff <= req_address;
      end
      if (dp_cmd.compare) begin
         gt_ff <= gt_in;
         ge_ff <= ge_in;
         eq_ff <= eq_in;
      end
      slots_ff <= slots_in;
      if (dp_cmd.load_rsp) begin
         rsp_status_ff  <= dp_cmd.rsp_status;
         rsp_present_ff <= dp_cmd.rsp_present;
         rsp_popped_ff  <= dp_cmd.take_head ? slots_ff[0] : '0;
         rsp_count_ff   <= COUNT_FIELD_W'(count_in);
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_present        = rsp_present_ff;
   assign rsp_popped_address = rsp_popped_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

// ===== hw/rtl/smt_checker.sv =====
// Port-level assertions for the membership table, bound to the top level.
module smt_checker
   import smt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A pending result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // One item at a time: an accept closes the input side for the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != STATUS_W'(3))
      else $error("undefined status code");

   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == STATUS_OK)
      else $error("present flagged with a failing status");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 31) || (int'(rsp_tdata[39:35]) <= CAPACITY))
      else $error("entry count beyond capacity");

endmodule

bind sorted_ip_membership_table smt_checker #(.CAPACITY(CAPACITY)) u_smt_checker (.*);
